// ----- hw/rtl/alc_pkg.sv -----
// Shared types and constants for the array list engine.
package alc_pkg;

  localparam int DATA_W       = 32;
  localparam int LEN_W        = 7;
  localparam int CMD_W        = 3;
  localparam int ST_W         = 2;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 3'd0,
    CMD_RESTORE = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_READ    = 3'd4,
    CMD_SEARCH  = 3'd5
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DELETE,
    S_SEARCH
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_RESTORE,
    OP_INSERT,
    OP_MARK,
    OP_BUBBLE
  } cell_op_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] value;
    logic [LEN_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  slen;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/alc_cell.sv -----
// One list cell: holds a working entry, a saved entry and a keep flag.
module alc_cell import alc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left_work,
  input  logic              left_keep,
  input  logic [DATA_W-1:0] right_work,
  input  logic              right_keep,
  output logic [DATA_W-1:0] work,
  output logic              keep,
  output logic              match,
  output logic              swap,
  output logic [DATA_W-1:0] rd_data
);

  localparam logic [LEN_W-1:0] POS0 = LEN_W'(IDX);
  localparam logic [LEN_W-1:0] POS1 = LEN_W'(IDX + 1);

  logic [DATA_W-1:0] saved;
  logic [DATA_W-1:0] work_next;
  logic [DATA_W-1:0] saved_next;
  logic              keep_next;
  logic              in_list;

  assign in_list = POS0 < ctl.len;
  assign match   = in_list && (work == ctl.value);
  // a hole directly below a kept entry pulls that entry down
  assign swap    = !keep && right_keep;
  assign rd_data = (ctl.pos == POS1) ? work : '0;

  always_comb begin
    work_next  = work;
    saved_next = saved;
    keep_next  = keep;
    unique case (ctl.op)
      OP_LOAD: begin
        if (ctl.len == POS0) work_next = ctl.value;
        if (ctl.slen == POS0) saved_next = ctl.value;
      end
      OP_RESTORE: work_next = saved;
      OP_INSERT: begin
        if (ctl.pos == POS1) work_next = ctl.value;
        else if (POS1 > ctl.pos) work_next = left_work;
      end
      OP_MARK: keep_next = in_list && (work != ctl.value);
      OP_BUBBLE: begin
        if (!keep && right_keep) begin
          work_next = right_work;
          keep_next = 1'b1;
        end else if (keep && !left_keep) begin
          keep_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    work  <= work_next;
    saved <= saved_next;
    keep  <= keep_next;
  end

endmodule

// ----- hw/rtl/array_list_engine_unit.sv -----
// Bounded list of signed 32-bit values held in a chain of CAPACITY cells, one command per
// input transaction. Load, restore, insert, read and unused codes finish in the cycle they
// are accepted; their result is registered and a new command can be taken in the next cycle
// once the output is free. Delete marks matches in every cell at once, then compacts survivors
// by moving them one cell down per cycle through the chain while a counter tallies the removed
// entries; it finishes once both the match walk and the compaction ripple are done. Search
// walks the match vector one cell per cycle up to the last match, pausing on a match while the
// output is stalled, and returns one result per match, last flag on the final one; a search
// with no match returns not-found in the cycle it is accepted.
module array_list_engine_unit import alc_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [DATA_W-1:0] value,
  input  logic [LEN_W-1:0]         position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ST_W-1:0]          status,
  output logic signed [DATA_W-1:0] value_res,
  output logic [LEN_W-1:0]         position_res,
  output logic [LEN_W-1:0]         count,
  output logic [LEN_W-1:0]         removed,
  output logic                     last
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);
  localparam logic [LEN_W-1:0] ONE_L = LEN_W'(1);

  state_t state, state_next;

  logic [LEN_W-1:0]    len, len_next;
  logic [LEN_W-1:0]    slen, slen_next;
  logic [CAPACITY-1:0] mvec, mvec_next;
  logic [LEN_W-1:0]    rm_cnt, rm_cnt_next;
  logic [IDX_W-1:0]    idx, idx_next;

  cell_ctl_t ctl;
  logic [DATA_W-1:0] work_w [CAPACITY];
  logic [DATA_W-1:0] rd_w   [CAPACITY];
  logic [CAPACITY-1:0] keep_w, match_w, swap_w;
  logic [DATA_W-1:0] rd_all;

  logic in_fire, out_free, any_swap, del_done, rest_zero;
  logic [LEN_W-1:0] len_p1;

  // result staging
  logic              emit;
  status_t           e_status;
  logic [DATA_W-1:0] e_value;
  logic [LEN_W-1:0]  e_pos;
  logic [LEN_W-1:0]  e_removed;
  logic              e_last;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] lw, rw;
      logic              lk, rk;
      if (g == 0) begin : g_lo
        assign lw = '0;
        assign lk = 1'b1;
      end else begin : g_lo
        assign lw = work_w[g-1];
        assign lk = keep_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_hi
        assign rw = '0;
        assign rk = 1'b0;
      end else begin : g_hi
        assign rw = work_w[g+1];
        assign rk = keep_w[g+1];
      end
      alc_cell #(.IDX(g)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .left_work  (lw),
        .left_keep  (lk),
        .right_work (rw),
        .right_keep (rk),
        .work       (work_w[g]),
        .keep       (keep_w[g]),
        .match      (match_w[g]),
        .swap       (swap_w[g]),
        .rd_data    (rd_w[g])
      );
    end
  endgenerate

  always_comb begin
    rd_all = '0;
    for (int i = 0; i < CAPACITY; i++) rd_all = rd_all | rd_w[i];
  end

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign any_swap  = |swap_w;
  assign rest_zero = (mvec >> 1) == '0;
  assign del_done  = (mvec == '0) && !any_swap;
  assign len_p1    = len + ONE_L;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_DELETE) state_next = S_DELETE;
          else if (cmd == CMD_SEARCH && match_w != '0) state_next = S_SEARCH;
        end
      end
      S_DELETE: if (del_done) state_next = S_IDLE;
      S_SEARCH: if (mvec[0] && out_free && rest_zero) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    ctl.op      = OP_NONE;
    ctl.value   = value;
    ctl.pos     = position;
    ctl.len     = len;
    ctl.slen    = slen;
    len_next    = len;
    slen_next   = slen;
    mvec_next   = mvec;
    rm_cnt_next = rm_cnt;
    idx_next    = idx;
    emit        = 1'b0;
    e_status    = ST_OK;
    e_value     = '0;
    e_pos       = '0;
    e_removed   = '0;
    e_last      = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd_t'(cmd))
            CMD_LOAD: begin
              emit = 1'b1;
              if (len >= CAP_L || slen >= CAP_L) begin
                e_status = ST_FULL;
              end else begin
                ctl.op    = OP_LOAD;
                len_next  = len_p1;
                slen_next = slen + ONE_L;
              end
            end
            CMD_RESTORE: begin
              emit     = 1'b1;
              ctl.op   = OP_RESTORE;
              len_next = slen;
            end
            CMD_INSERT: begin
              emit = 1'b1;
              if (len >= CAP_L) begin
                e_status = ST_FULL;
              end else if (position == '0 || position > len_p1) begin
                e_status = ST_BADPOS;
              end else begin
                ctl.op   = OP_INSERT;
                len_next = len_p1;
              end
            end
            CMD_DELETE: begin
              ctl.op      = OP_MARK;
              mvec_next   = match_w;
              rm_cnt_next = '0;
            end
            CMD_READ: begin
              emit = 1'b1;
              if (position == '0 || position > len) e_status = ST_BADPOS;
              else e_value = rd_all;
            end
            CMD_SEARCH: begin
              if (match_w == '0) begin
                emit     = 1'b1;
                e_status = ST_NOTFOUND;
              end
              mvec_next = match_w;
              idx_next  = '0;
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_DELETE: begin
        ctl.op = OP_BUBBLE;
        if (mvec[0]) rm_cnt_next = rm_cnt + ONE_L;
        mvec_next = mvec >> 1;
        if (del_done) begin
          emit      = 1'b1;
          len_next  = len - rm_cnt;
          e_status  = (rm_cnt == '0) ? ST_NOTFOUND : ST_OK;
          e_removed = rm_cnt;
        end
      end
      S_SEARCH: begin
        if (!mvec[0] || out_free) begin
          mvec_next = mvec >> 1;
          idx_next  = idx + IDX_W'(1);
        end
        if (mvec[0] && out_free) begin
          emit   = 1'b1;
          e_pos  = LEN_W'(idx) + ONE_L;
          e_last = rest_zero;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      slen      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      slen  <= slen_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mvec   <= mvec_next;
    rm_cnt <= rm_cnt_next;
    idx    <= idx_next;
    if (emit) begin
      status       <= e_status;
      value_res    <= e_value;
      position_res <= e_pos;
      count        <= len_next;
      removed      <= e_removed;
      last         <= e_last;
    end
  end

endmodule
